[sv/ipv4_dotted_address_parser_macros.svh]
// Assertion helpers shared by the address parser modules.
`ifndef IPV4_DOTTED_ADDRESS_PARSER_MACROS_SVH
`define IPV4_DOTTED_ADDRESS_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ipd_pkg.sv]
// ----------------------------------------------------------------------------
// ipd_pkg
// Types, codes and character constants for the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

   // Parse phase codes
   localparam logic [1:0] PH_EXPECT = 2'd0;
   localparam logic [1:0] PH_ZERO   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   // Radix codes
   localparam logic [1:0] RX_DEC = 2'd0;
   localparam logic [1:0] RX_OCT = 2'd1;
   localparam logic [1:0] RX_HEX = 2'd2;

   // Characters
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_F  = 8'h46;
   localparam logic [7:0] CH_UC_X  = 8'h58;
   localparam logic [7:0] CH_LC_A  = 8'h61;
   localparam logic [7:0] CH_LC_F  = 8'h66;
   localparam logic [7:0] CH_LC_X  = 8'h78;

   localparam logic [1:0]  MAX_EARLIER = 2'd3;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0] character;
      logic       first_char;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] address;
   } rsp_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

[sv/ipd_in_stage.sv]
// ----------------------------------------------------------------------------
// ipd_in_stage
// Input register: holds one character until the parse logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_in_stage
   import ipd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   input  wire logic    advance,
   output logic         item_valid,
   output req_type      item
);

   logic    vld_ff, vld_in;
   req_type item_ff, item_in;
   logic    take;

   // A new transfer is taken whenever the register is empty or drains now.
   assign req_stall = vld_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (take) begin
         vld_in  = 1'b1;
         item_in = req_item;
      end else if (advance) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[sv/ipd_parse.sv]
// ----------------------------------------------------------------------------
// ipd_parse
// Parse state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_dotted_address_parser_macros.svh"

module ipd_parse
   import ipd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire req_type item,
   output logic         res_valid,
   output rsp_type      res
);

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  radix_ff, radix_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  count_ff, count_in;
   logic [31:0] parts_ff [3];
   logic        part_we;

   logic [7:0]  c;
   logic [1:0]  ph, rx, pc, eff_rx;
   logic [31:0] acc, scaled, packed_val;
   logic        is_dec, is_ws, is_hex_lc, is_hex_uc, is_digit;
   logic [3:0]  dval;
   logic        last_big, parts_bad, good;

   always_comb begin
      c = item.character;
      // A start flag clears the parse before this character is looked at.
      ph  = item.first_char ? PH_EXPECT : phase_ff;
      rx  = item.first_char ? RX_DEC : radix_ff;
      acc = item.first_char ? 32'd0 : acc_ff;
      pc  = item.first_char ? 2'd0 : count_ff;

      is_dec    = (c >= CH_ZERO) && (c <= CH_NINE);
      is_ws     = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      is_hex_lc = (c >= CH_LC_A) && (c <= CH_LC_F);
      is_hex_uc = (c >= CH_UC_A) && (c <= CH_UC_F);

      // After a leading zero the part is octal unless an x follows.
      eff_rx   = (ph == PH_ZERO) ? RX_OCT : rx;
      is_digit = is_dec || ((eff_rx == RX_HEX) && (is_hex_lc || is_hex_uc));
      dval     = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);

      case (eff_rx)
         RX_HEX:  scaled = acc << 4;
         RX_OCT:  scaled = acc << 3;
         default: scaled = (acc << 3) + (acc << 1);
      endcase

      // Packing: the last part must fit its field, earlier parts one octet.
      case (pc)
         2'd1:    last_big = acc[31:24] != 8'd0;
         2'd2:    last_big = acc[31:16] != 16'd0;
         2'd3:    last_big = acc[31:8] != 24'd0;
         default: last_big = 1'b0;
      endcase
      parts_bad = ((pc >= 2'd1) && (parts_ff[0][31:8] != 24'd0))
                || ((pc >= 2'd2) && (parts_ff[1][31:8] != 24'd0))
                || ((pc >= 2'd3) && (parts_ff[2][31:8] != 24'd0));
      packed_val = acc;
      if (pc >= 2'd1) packed_val = packed_val | {parts_ff[0][7:0], 24'd0};
      if (pc >= 2'd2) packed_val = packed_val | {8'd0, parts_ff[1][7:0], 16'd0};
      if (pc >= 2'd3) packed_val = packed_val | {16'd0, parts_ff[2][7:0], 8'd0};

      phase_in  = ph;
      radix_in  = rx;
      acc_in    = acc;
      count_in  = pc;
      part_we   = 1'b0;
      res_valid = 1'b0;
      good      = 1'b0;

      case (ph)
         PH_EXPECT: begin
            if (!is_dec) begin
               res_valid = 1'b1;
               phase_in  = PH_DONE;
            end else if (c == CH_ZERO) begin
               acc_in   = 32'd0;
               phase_in = PH_ZERO;
            end else begin
               radix_in = RX_DEC;
               acc_in   = {28'd0, c[3:0]};
               phase_in = PH_DIGITS;
            end
         end
         PH_ZERO, PH_DIGITS: begin
            phase_in = PH_DIGITS;
            if (ph == PH_ZERO) begin
               radix_in = RX_OCT;
            end
            if ((ph == PH_ZERO) && ((c == CH_LC_X) || (c == CH_UC_X))) begin
               radix_in = RX_HEX;
            end else if (is_digit) begin
               acc_in = scaled + {28'd0, dval};
            end else if (c == CH_DOT) begin
               if (pc == MAX_EARLIER) begin
                  res_valid = 1'b1;
                  phase_in  = PH_DONE;
               end else begin
                  part_we  = 1'b1;
                  count_in = pc + 2'd1;
                  acc_in   = 32'd0;
                  phase_in = PH_EXPECT;
               end
            end else begin
               res_valid = 1'b1;
               phase_in  = PH_DONE;
               good      = ((c == CH_NUL) || is_ws) && !last_big && !parts_bad;
            end
         end
         default: begin
         end
      endcase

      res.ok      = good;
      res.address = good ? swap32(packed_val) : ALL_ONES;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_EXPECT;
         radix_ff <= RX_DEC;
         acc_ff   <= 32'd0;
         count_ff <= 2'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
      if (advance && part_we) begin
         parts_ff[pc] <= acc;
      end
   end

   `IPD_ASSERT_NEXT(a_done_after_result, clock, reset, advance && res_valid, phase_ff == PH_DONE, "parser not finished after a result")
   `IPD_ASSERT_NOW(a_no_result_when_done, clock, reset, (phase_ff == PH_DONE) && !item.first_char, !res_valid, "result after the string had ended")

endmodule

`default_nettype wire

[sv/ipd_out_stage.sv]
// ----------------------------------------------------------------------------
// ipd_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_out_stage
   import ipd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type res,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   logic    vld_ff, vld_in;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      vld_in = vld_ff;
      rsp_in = rsp_ff;
      if (load) begin
         vld_in = 1'b1;
         rsp_in = res;
      end else if (vld_ff && !rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

[sv/ipv4_dotted_address_parser.sv]
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser
// Parses a dotted IPv4 address (a, a.b, a.b.c, a.b.c.d; decimal, octal or
// hex parts) one character per transfer and returns the packed address.
//
//   channel   direction  ports
//   req       in         req_valid, req_stall, req_character, req_first_char
//   rsp       out        rsp_valid, rsp_stall, rsp_ok, rsp_address
//
// One character per cycle while rsp is not stalled; a character goes from the
// input register through the single parse pass into the result register.
// At most one result per string, on the character that ends it.
// Reset is synchronous and clears both stages and the parse state.
// A held result stalls the input only once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_dotted_address_parser_macros.svh"

module ipv4_dotted_address_parser
   import ipd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_character,
   input  wire logic        req_first_char,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_ok,
   output logic [31:0]      rsp_address
);

   req_type req_item, item;
   rsp_type res, rsp_item;
   logic    item_valid, advance, res_valid, load;

   assign req_item.character  = req_character;
   assign req_item.first_char = req_first_char;

   // The held character moves on when the result register is free or drains.
   assign advance = item_valid && (!rsp_valid || !rsp_stall);
   assign load    = advance && res_valid;

   ipd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ipd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   ipd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .res       (res),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_ok      = rsp_item.ok;
   assign rsp_address = rsp_item.address;

   `IPD_ASSERT_NOW(a_load_when_free, clock, reset, load, !rsp_valid || !rsp_stall, "result register overwritten while held")
   `IPD_ASSERT_NOW(a_stall_only_full, clock, reset, req_stall, item_valid, "input stalled with an empty input register")
   `IPD_ASSERT_NOW(a_fail_all_ones, clock, reset, rsp_valid && !rsp_ok, rsp_address == ALL_ONES, "failed result without all-ones address")

endmodule

`default_nettype wire

[bench/tb_ipv4_dotted_address_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_address_parser
// Self-checking bench for the dotted IPv4 address parser. Characters are
// streamed in through the req channel with random gaps, and the rsp channel
// is stalled at random. A behavioural parser inside the bench predicts the
// result of every string, and the results are compared field by field in
// arrival order. Directed strings cover the address forms, the radixes and
// each failure case. Random well-formed addresses follow, mixed with broken
// strings and noise.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_address_parser;
   import ipd_pkg::*;

   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_VT   = 8'h0B;
   localparam logic [7:0] CH_FF   = 8'h0C;
   localparam logic [7:0] CH_HIGH = 8'hFF;

   localparam int unsigned TARGET_CHARS = 1150;
   localparam int unsigned HOLD_CYCLES  = 100;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned IDLE_LIMIT   = 2000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character  = 8'h00;
   logic        req_first_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic        rsp_ok;
   logic [31:0] rsp_address;

   // Bench copy of the parse state.
   logic [1:0]  scan_phase   = PH_EXPECT;
   logic [1:0]  scan_radix   = RX_DEC;
   logic [31:0] part_value   = '0;
   logic [31:0] dotted_parts [3];
   logic [1:0]  dotted_count = '0;

   rsp_type     pending_results [$];
   int unsigned mismatch_count = 0;
   int unsigned live_chars     = 0;
   int unsigned idle_cycles    = 0;
   bit          gap_enable     = 1'b1;
   bit          stall_enable   = 1'b1;
   bit          hold_off_req   = 1'b0;

   ipv4_dotted_address_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_character  (req_character),
      .req_first_char (req_first_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_address    (rsp_address)
   );

   always #5 clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Advances the bench parser by one character. closes is set when the
   // character ends the string and a result is due.
   function automatic void parse_character(input logic [7:0] ch, input logic start,
                                           output bit closes, output logic good,
                                           output logic [31:0] packed_addr);
      logic        is_digit;
      logic        is_space;
      logic        run_digits;
      logic [31:0] mul;
      logic [31:0] value;
      logic [31:0] span;
      logic [7:0]  nibble;
      closes      = 1'b0;
      good        = 1'b0;
      packed_addr = ALL_ONES;
      run_digits  = 1'b0;
      is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
      is_space    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
      if (start) begin
         scan_phase   = PH_EXPECT;
         scan_radix   = RX_DEC;
         part_value   = '0;
         dotted_count = '0;
      end
      case (scan_phase)
         PH_EXPECT: begin
            if (!is_digit) begin
               closes = 1'b1;
            end else if (ch == CH_ZERO) begin
               part_value = '0;
               scan_phase = PH_ZERO;
            end else begin
               scan_radix = RX_DEC;
               part_value = 32'(ch - CH_ZERO);
               scan_phase = PH_DIGITS;
            end
         end
         PH_ZERO: begin
            scan_phase = PH_DIGITS;
            if (ch == CH_LC_X || ch == CH_UC_X) begin
               scan_radix = RX_HEX;
            end else begin
               scan_radix = RX_OCT;
               run_digits = 1'b1;
            end
         end
         PH_DIGITS: run_digits = 1'b1;
         default: ;
      endcase
      if (run_digits) begin
         mul = (scan_radix == RX_HEX) ? 32'd16 : (scan_radix == RX_OCT) ? 32'd8 : 32'd10;
         if (is_digit) begin
            part_value = part_value * mul + 32'(ch - CH_ZERO);
         end else if (scan_radix == RX_HEX && ch >= CH_LC_A && ch <= CH_LC_F) begin
            nibble     = ch - CH_LC_A + 8'd10;
            part_value = {part_value[27:0], nibble[3:0]};
         end else if (scan_radix == RX_HEX && ch >= CH_UC_A && ch <= CH_UC_F) begin
            nibble     = ch - CH_UC_A + 8'd10;
            part_value = {part_value[27:0], nibble[3:0]};
         end else if (ch == CH_DOT) begin
            if (dotted_count >= MAX_EARLIER) begin
               closes = 1'b1;
            end else begin
               dotted_parts[dotted_count] = part_value;
               dotted_count = dotted_count + 2'd1;
               part_value   = '0;
               scan_phase   = PH_EXPECT;
            end
         end else if (ch == CH_NUL || is_space) begin
            // Pack the parts: the last one fills whatever the earlier ones leave.
            closes = 1'b1;
            good   = 1'b1;
            value  = part_value;
            if (dotted_count != 0) begin
               span = (dotted_count == 1) ? 32'h00FF_FFFF :
                      (dotted_count == 2) ? 32'h0000_FFFF : 32'h0000_00FF;
               if (value > span) good = 1'b0;
               for (int i = 0; i < dotted_count; i++) begin
                  if (dotted_parts[i] > 32'd255) good = 1'b0;
                  value = value | (dotted_parts[i] << (24 - 8 * i));
               end
            end
            if (good) packed_addr = {<<8{value}};
         end else begin
            closes = 1'b1;
         end
      end
      if (closes) scan_phase = PH_DONE;
   endfunction

   task automatic send_char(input logic [7:0] ch, input logic start);
      bit          closes;
      logic        good;
      logic [31:0] packed_addr;
      int unsigned gap;
      req_valid      <= 1'b1;
      req_character  <= ch;
      req_first_char <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      live_chars++;
      parse_character(ch, start, closes, good, packed_addr);
      if (closes) pending_results.push_back('{ok: good, address: packed_addr});
      gap = gap_enable ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string text, input logic [7:0] ender, input logic start);
      for (int i = 0; i < text.len(); i++) send_char(text[i], start && (i == 0));
      send_char(ender, start && (text.len() == 0));
   endtask

   function automatic string format_part(input logic [31:0] value);
      string       s;
      int unsigned k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: s = $sformatf("%0d", value);
         5: s = $sformatf("0%0o", value);
         6: s = $sformatf("0x%0h", value);
         7: begin
            s = $sformatf("0x%0h", value);
            s = s.toupper();
         end
         8: begin
            // Free digit run: reaches octal with 8 and 9, and wraps when long.
            s = "";
            k = $urandom_range(1, 12);
            repeat (k) s = $sformatf("%s%c", s, 8'($urandom_range(CH_ZERO, CH_NINE)));
         end
         default: s = ($urandom_range(0, 2) == 0) ? "" : "0x";
      endcase
      return s;
   endfunction

   function automatic string make_address();
      string       text;
      int unsigned parts;
      logic [31:0] span;
      logic [31:0] value;
      parts = $urandom_range(1, 4);
      text  = "";
      for (int i = 0; i < parts - 1; i++) begin
         value = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 255);
         text  = {text, format_part(value), "."};
      end
      case (parts)
         1: span = 32'hFFFF_FFFF;
         2: span = 32'h00FF_FFFF;
         3: span = 32'h0000_FFFF;
         default: span = 32'h0000_00FF;
      endcase
      value = ($urandom_range(0, 9) == 0) ? $urandom() : ($urandom() & span);
      text  = {text, format_part(value)};
      if ($urandom_range(0, 15) == 0) text = {text, ".", format_part($urandom_range(0, 255))};
      return text;
   endfunction

   function automatic logic [7:0] pick_ender();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return CH_NUL;
      if (roll == 9) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_LF;
         3: return CH_VT;
         4: return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   task automatic test_start_after_reset();
      // The very first string carries no start flag.
      send_text("10.1", CH_NUL, 1'b0);
   endtask

   task automatic test_address_forms();
      send_text("4294967295", CH_TAB, 1'b1);
      send_text("0x7f.1", CH_CR, 1'b1);
      send_text("0377.0XaB.0.255", CH_NUL, 1'b1);
      send_text("1.16777215", CH_LF, 1'b1);
      send_text("1.2.65535", CH_VT, 1'b1);
      send_text("0x", CH_FF, 1'b1);
      send_text("089", CH_SPACE, 1'b1);
      send_text("99999999999", CH_NUL, 1'b1);
   endtask

   task automatic test_failures();
      send_text("", CH_DOT, 1'b1);
      send_text("", CH_NUL, 1'b1);
      send_text("1.2.3.4.5", CH_NUL, 1'b1);
      send_text("1.2.3.256", CH_NUL, 1'b1);
      send_text("256.1.2.3", CH_NUL, 1'b1);
      send_text("1.16777216", CH_NUL, 1'b1);
      send_text("1a", CH_NUL, 1'b1);
      send_text("7", CH_HIGH, 1'b1);
      send_text("1.", CH_NUL, 1'b1);
   endtask

   task automatic test_restart_and_tail();
      // An unfinished string is dropped when a new start arrives, and bytes
      // after a finished string are ignored until the next start.
      send_text("1.2", CH_DOT, 1'b1);
      send_text("3.4", CH_NUL, 1'b1);
      send_char(CH_NINE, 1'b0);
      send_char(CH_SPACE, 1'b0);
   endtask

   task automatic test_back_pressure();
      gap_enable   = 1'b0;
      hold_off_req = 1'b1;
      repeat (8) send_text("10.20.30.40", CH_NUL, 1'b1);
      gap_enable   = 1'b1;
   endtask

   task automatic test_random_traffic();
      string       text;
      int unsigned stretch;
      int unsigned count;
      stretch = 0;
      while (live_chars < TARGET_CHARS) begin
         if (stretch == 0) begin
            stretch      = $urandom_range(20, 60);
            gap_enable   = ($urandom_range(0, 3) != 0);
            stall_enable = ($urandom_range(0, 3) != 0);
         end
         stretch--;
         if ($urandom_range(0, 9) == 0) begin
            count = $urandom_range(1, 10);
            for (int i = 0; i < count; i++)
               send_char(8'($urandom_range(0, 255)), (i == 0) || ($urandom_range(0, 9) == 0));
         end else begin
            text = make_address();
            send_text(text, pick_ender(), 1'b1);
            if ($urandom_range(0, 4) == 0) begin
               count = $urandom_range(1, 4);
               repeat (count) send_char(8'($urandom_range(0, 255)), 1'b0);
            end
         end
      end
      gap_enable   = 1'b1;
      stall_enable = 1'b1;
   endtask

   // Receiver stall pattern; a requested hold-off is timed here.
   initial begin : rsp_stall_driver
      int unsigned busy;
      int unsigned free;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            busy = HOLD_CYCLES;
         end else begin
            busy = stall_enable ? pick_gap() : 0;
         end
         free = $urandom_range(1, 6);
         if (busy != 0) begin
            rsp_stall <= 1'b1;
            repeat (busy) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (free) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: ok %0b, address %08h", rsp_ok, rsp_address);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0b, actual %0b", want.ok, rsp_ok);
               mismatch_count++;
            end
            if (rsp_address !== want.address) begin
               $error("address: expected %08h, actual %08h", want.address, rsp_address);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : run
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_start_after_reset();
      test_address_forms();
      test_failures();
      test_restart_and_tail();
      test_back_pressure();
      test_random_traffic();
      req_valid    <= 1'b0;
      stall_enable  = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
